@@ rtl/bni_pkg.sv @@
// ----------------------------------------------------------------------------
// Batch normalization package
// Shared types, constants and the saturation helper.
// ----------------------------------------------------------------------------
package bni_pkg;

  localparam int unsigned ChW  = 8;
  localparam int unsigned QW   = 32;
  localparam int unsigned EpsW = 16;

  localparam logic signed [QW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] QMin = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COEF,
    ST_OFS_MUL,
    ST_OFS_WR,
    ST_RD,
    ST_MUL,
    ST_OUT
  } bni_state_e;

  typedef enum logic [2:0] {
    CU_IDLE,
    CU_SQRT,
    CU_PREP,
    CU_DIV,
    CU_DONE
  } bni_cu_state_e;

  typedef struct packed {
    logic                 clip;
    logic signed [QW-1:0] val;
  } bni_sat_t;

  // Clamp a wide signed value to the Q16.16 range.
  function automatic bni_sat_t sat32(input logic signed [65:0] v);
    bni_sat_t r;
    if (v > 66'(QMax)) begin
      r.clip = 1'b1;
      r.val  = QMax;
    end else if (v < 66'(QMin)) begin
      r.clip = 1'b1;
      r.val  = QMin;
    end else begin
      r.clip = 1'b0;
      r.val  = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/bni_if.sv @@
// ----------------------------------------------------------------------------
// Batch normalization channels
// Valid/ready interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface bni_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [7:0]         channel;
  logic signed [31:0] sample;
  logic signed [31:0] scale;
  logic signed [31:0] mean;
  logic [31:0]        variance;
  logic signed [31:0] bias;

  modport source (output valid, func, channel, sample, scale, mean, variance, bias,
                  input ready);
  modport sink (input valid, func, channel, sample, scale, mean, variance, bias,
                output ready);
endinterface

interface bni_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic [7:0]         out_channel;
  logic               saturated;

  modport source (output valid, out_value, out_channel, saturated, input ready);
  modport sink (input valid, out_value, out_channel, saturated, output ready);
endinterface

@@ rtl/batch_norm_inference.sv @@
// ----------------------------------------------------------------------------
// Batch normalization for inference
// Per-channel Q16.16 normalization with a gain/offset table in RAM.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_i. A load item (func 0) computes the channel's
// gain and offset and writes them to the coefficient RAM; it produces no
// result. A sample item (func 1) reads its channel's entry and returns
// gain*sample+offset, saturated, on out_o. A channel must be loaded before a
// sample of it is sent.
// One item is in work at a time. A sample passes the RAM read, the shared
// 32x32 multiplier and the final add in turn; the next item is taken only
// after its result is registered. A load runs 25 square root steps and 48
// divide steps, one bit each, in the gain unit, then a multiply and a write.
// The result sits in an output register; if the receiver stalls, the next
// item is still taken and completes up to its last stage, where it waits.
// Reset sets epsilon to 1 and clears all control state; the RAM contents
// stay undefined until loaded. epsilon is written through cfg_we_i; the user
// must write it only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module batch_norm_inference
  import bni_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [EpsW-1:0] cfg_wdata_i,
  bni_in_if.sink          in_i,
  bni_out_if.source       out_o
);

  localparam int unsigned AddrW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  bni_state_e state_q, state_d;

  logic [EpsW-1:0]      epsilon_q;
  logic [ChW-1:0]       ch_q;
  logic                 in_range_q;
  logic signed [31:0]   sample_q, mean_q, bias_q, gain_q;
  logic signed [63:0]   prod_q;
  logic                 ovalid_q;
  logic signed [31:0]   oval_q;
  logic [ChW-1:0]       och_q;
  logic                 osat_q;

  logic                 accept, start, out_load, mem_we, cu_done;
  logic signed [31:0]   cu_gain, mul_a, mul_b;
  logic [AddrW-1:0]     addr;
  logic [63:0]          rdata;
  logic signed [47:0]   ofs_rnd;
  logic signed [31:0]   offset;
  logic signed [49:0]   res_sh;
  bni_sat_t             ofs_sat, res_sat;

  assign accept   = in_i.valid & in_i.ready;
  assign start    = accept & ~in_i.func;
  assign addr     = AddrW'({5'b0, ch_q});
  assign out_load = (state_q == ST_OUT) & (~ovalid_q | out_o.ready);
  assign mem_we   = (state_q == ST_OFS_WR) & in_range_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (accept) state_d = in_i.func ? ST_RD : ST_COEF;
      ST_COEF:    if (cu_done) state_d = ST_OFS_MUL;
      ST_OFS_MUL: state_d = ST_OFS_WR;
      ST_OFS_WR:  state_d = ST_IDLE;
      ST_RD:      state_d = ST_MUL;
      ST_MUL:     state_d = ST_OUT;
      ST_OUT:     if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    if (state_q == ST_OFS_MUL) begin
      mul_a = gain_q;
      mul_b = mean_q;
    end else begin
      mul_a = rdata[63:32];
      mul_b = sample_q;
    end
  end

  // offset = bias - floor((gain*mean + 2^15) / 2^16)
  assign ofs_rnd = 48'((prod_q + 64'sd32768) >>> 16);
  assign ofs_sat = sat32(66'(bias_q) - 66'(ofs_rnd));

  // result = floor((gain*x + offset*2^16 + 2^15) / 2^16)
  assign offset  = rdata[31:0];
  assign res_sh  = 50'((66'(prod_q) + (66'(offset) <<< 16) + 66'sd32768) >>> 16);
  assign res_sat = sat32(66'(res_sh));

  bni_coef_unit u_coef (
    .clk_i,
    .rst_ni,
    .start_i    (start),
    .variance_i (in_i.variance),
    .epsilon_i  (epsilon_q),
    .scale_i    (in_i.scale),
    .done_o     (cu_done),
    .gain_o     (cu_gain)
  );

  bni_ram #(
    .Width (64),
    .Depth (MAX_CHANNELS)
  ) u_table (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (addr),
    .wdata_i ({gain_q, ofs_sat.val}),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      epsilon_q <= EpsW'(1);
      ovalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        epsilon_q <= cfg_wdata_i;
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q       <= in_i.channel;
      in_range_q <= ({5'b0, in_i.channel} < 13'(MAX_CHANNELS));
      sample_q   <= in_i.sample;
      mean_q     <= in_i.mean;
      bias_q     <= in_i.bias;
    end
    if (state_q == ST_COEF && cu_done) begin
      gain_q <= cu_gain;
    end
    prod_q <= mul_a * mul_b;
    if (out_load) begin
      och_q  <= ch_q;
      oval_q <= in_range_q ? res_sat.val : '0;
      osat_q <= in_range_q & res_sat.clip;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.out_value   = oval_q;
  assign out_o.out_channel = och_q;
  assign out_o.saturated   = osat_q;

endmodule

@@ rtl/bni_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bni_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/bni_coef_unit.sv @@
// ----------------------------------------------------------------------------
// Gain unit
// Bit-serial square root of the guarded variance, then a restoring divide
// that yields the rounded, saturated channel gain.
// ----------------------------------------------------------------------------
module bni_coef_unit
  import bni_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [31:0]          variance_i,
  input  logic [EpsW-1:0]      epsilon_i,
  input  logic signed [31:0]   scale_i,
  output logic                 done_o,
  output logic signed [QW-1:0] gain_o
);

  bni_cu_state_e state_q, state_d;

  logic [49:0] rad_q, res_q, bit_q;
  logic [31:0] mag_q;
  logic        neg_q;
  logic [24:0] den_q;
  logic [47:0] num_q;
  logic [25:0] rem_q;
  logic [5:0]  cnt_q;

  logic [32:0] sum;
  logic [49:0] trial;
  logic [25:0] rtry;

  assign sum   = {1'b0, variance_i} + {17'b0, epsilon_i};
  assign trial = res_q + bit_q;
  assign rtry  = {rem_q[24:0], num_q[47]};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CU_IDLE: if (start_i) state_d = CU_SQRT;
      CU_SQRT: if (bit_q[0]) state_d = CU_PREP;
      CU_PREP: state_d = CU_DIV;
      CU_DIV:  if (cnt_q == '0) state_d = CU_DONE;
      CU_DONE: state_d = CU_IDLE;
      default: state_d = CU_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == CU_DONE);
    if (!neg_q) begin
      gain_o = (num_q > 48'h7FFF_FFFF) ? QMax : num_q[31:0];
    end else begin
      gain_o = (num_q > 48'h8000_0000) ? QMin : -num_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      CU_IDLE: begin
        if (start_i) begin
          // A zero sum only happens with epsilon written as zero.
          rad_q <= {1'b0, (sum == '0) ? 33'd1 : sum, 16'b0};
          res_q <= '0;
          bit_q <= 50'(1) << 48;
          neg_q <= scale_i[31];
          mag_q <= scale_i[31] ? 32'(-scale_i) : 32'(scale_i);
        end
      end
      CU_SQRT: begin
        if (rad_q >= trial) begin
          rad_q <= rad_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      CU_PREP: begin
        den_q <= res_q[24:0];
        num_q <= {mag_q, 16'b0} + 48'(res_q[24:1]);
        rem_q <= '0;
        cnt_q <= 6'd47;
      end
      CU_DIV: begin
        // The quotient bits shift in where the numerator bits leave.
        if (rtry >= {1'b0, den_q}) begin
          rem_q <= rtry - {1'b0, den_q};
          num_q <= {num_q[46:0], 1'b1};
        end else begin
          rem_q <= rtry;
          num_q <= {num_q[46:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/bni_checker.sv @@
// ----------------------------------------------------------------------------
// Batch normalization checker
// Port-level properties of the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bni_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic        saturated
);

  // No result is shown while reset is applied.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result valid during reset");

  // One item at a time: the block is busy right after a transfer in.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // A result is registered before the block goes idle, never directly after a transfer in.
  a_no_late_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after a transfer in");

  // A clipped result sits at one of the range limits.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && saturated |-> out_value == 32'h7FFF_FFFF || out_value == 32'h8000_0000)
    else $error("saturated result not at a limit");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind batch_norm_inference bni_checker u_bni_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_value (out_o.out_value),
  .saturated (out_o.saturated)
);
